@@ rtl/core/brf_pkg.sv @@
// shared types, constants and helper functions of the banked register file
package brf_pkg;

	// command codes
	localparam logic [3:0] CMD_READ       = 4'd0;
	localparam logic [3:0] CMD_WRITE      = 4'd1;
	localparam logic [3:0] CMD_READ_MODE  = 4'd2;
	localparam logic [3:0] CMD_WRITE_MODE = 4'd3;
	localparam logic [3:0] CMD_SPSR_READ  = 4'd4;
	localparam logic [3:0] CMD_SPSR_WRITE = 4'd5;
	localparam logic [3:0] CMD_CPSR_READ  = 4'd6;
	localparam logic [3:0] CMD_CPSR_WRITE = 4'd7;
	localparam logic [3:0] CMD_COND       = 4'd8;
	localparam logic [3:0] CMD_SWI        = 4'd9;

	// processor modes
	localparam logic [4:0] MODE_USR = 5'h10;
	localparam logic [4:0] MODE_FIQ = 5'h11;
	localparam logic [4:0] MODE_IRQ = 5'h12;
	localparam logic [4:0] MODE_SVC = 5'h13;
	localparam logic [4:0] MODE_ABT = 5'h17;
	localparam logic [4:0] MODE_UND = 5'h1B;
	localparam logic [4:0] MODE_SYS = 5'h1F;

	// condition codes
	localparam logic [3:0] COND_EQ = 4'd0;
	localparam logic [3:0] COND_NE = 4'd1;
	localparam logic [3:0] COND_CS = 4'd2;
	localparam logic [3:0] COND_CC = 4'd3;
	localparam logic [3:0] COND_MI = 4'd4;
	localparam logic [3:0] COND_PL = 4'd5;
	localparam logic [3:0] COND_VS = 4'd6;
	localparam logic [3:0] COND_VC = 4'd7;
	localparam logic [3:0] COND_HI = 4'd8;
	localparam logic [3:0] COND_LS = 4'd9;
	localparam logic [3:0] COND_GE = 4'd10;
	localparam logic [3:0] COND_LT = 4'd11;
	localparam logic [3:0] COND_GT = 4'd12;
	localparam logic [3:0] COND_LE = 4'd13;
	localparam logic [3:0] COND_AL = 4'd14;

	localparam logic [3:0] REG_PC = 4'd15;

	// reset values
	localparam logic [31:0] STACK_USR_RESET = 32'h0300_7F00;
	localparam logic [31:0] STACK_SVC_RESET = 32'h0300_7FE0;
	localparam logic [31:0] STACK_IRQ_RESET = 32'h0300_7FA0;
	localparam logic [31:0] PC_RESET        = 32'h0800_0000;
	localparam logic [31:0] STATUS_RESET    = 32'h0000_005F;
	localparam logic [31:0] SWI_VECTOR      = 32'h0000_0008;
	localparam logic [31:0] PC_ALIGN_MASK   = 32'hFFFF_FFFE;
	localparam logic [31:0] SWI_CLEAR_MASK  = 32'h0000_023F;
	localparam logic [31:0] IRQ_MASK_BIT    = 32'h0000_0080;

	// register memory layout: r0-r14 user, then fiq r8-r14, then r13/r14 of svc, abt, irq, und
	localparam int REG_DEPTH  = 30;
	localparam int REG_ADDR_W = 5;
	localparam logic [REG_ADDR_W-1:0] ADDR_USR_SP = 5'd13;
	localparam logic [REG_ADDR_W-1:0] OFS_FIQ     = 5'd7;
	localparam logic [REG_ADDR_W-1:0] OFS_SVC     = 5'd9;
	localparam logic [REG_ADDR_W-1:0] OFS_ABT     = 5'd11;
	localparam logic [REG_ADDR_W-1:0] OFS_IRQ     = 5'd13;
	localparam logic [REG_ADDR_W-1:0] OFS_UND     = 5'd15;
	localparam logic [REG_ADDR_W-1:0] ADDR_SVC_SP = 5'd22;
	localparam logic [REG_ADDR_W-1:0] ADDR_SVC_LR = 5'd23;
	localparam logic [REG_ADDR_W-1:0] ADDR_IRQ_SP = 5'd26;

	// saved status memory slots
	localparam int SAV_DEPTH  = 5;
	localparam int SAV_ADDR_W = 3;
	localparam logic [SAV_ADDR_W-1:0] SLOT_FIQ = 3'd0;
	localparam logic [SAV_ADDR_W-1:0] SLOT_IRQ = 3'd1;
	localparam logic [SAV_ADDR_W-1:0] SLOT_SVC = 3'd2;
	localparam logic [SAV_ADDR_W-1:0] SLOT_ABT = 3'd3;
	localparam logic [SAV_ADDR_W-1:0] SLOT_UND = 3'd4;

	typedef struct packed {
		logic                  hit;
		logic [REG_ADDR_W-1:0] addr;
	} reg_loc_t;

	typedef struct packed {
		logic                  hit;
		logic [SAV_ADDR_W-1:0] slot;
	} sav_loc_t;

	// storage location of r0-r14 seen in a mode
	function automatic reg_loc_t reg_loc(input logic [3:0] r, input logic [4:0] mode,
		input logic low_always);
		reg_loc_t loc;
		logic [REG_ADDR_W-1:0] ra;
		logic hi8;
		logic hi13;
		ra   = {1'b0, r};
		hi8  = (r >= 4'd8);
		hi13 = (r >= 4'd13);
		loc.hit  = 1'b1;
		loc.addr = ra;
		if (!(low_always && !hi8)) begin
			case (mode)
				MODE_USR, MODE_SYS: loc.addr = ra;
				MODE_FIQ: loc.addr = hi8 ? ra + OFS_FIQ : ra;
				MODE_SVC: loc.addr = hi13 ? ra + OFS_SVC : ra;
				MODE_ABT: loc.addr = hi13 ? ra + OFS_ABT : ra;
				MODE_IRQ: loc.addr = hi13 ? ra + OFS_IRQ : ra;
				MODE_UND: loc.addr = hi13 ? ra + OFS_UND : ra;
				default: begin
					loc.hit  = 1'b0;
					loc.addr = '0;
				end
			endcase
		end
		return loc;
	endfunction

	function automatic sav_loc_t sav_loc(input logic [4:0] mode);
		sav_loc_t loc;
		loc.hit = 1'b1;
		case (mode)
			MODE_FIQ: loc.slot = SLOT_FIQ;
			MODE_IRQ: loc.slot = SLOT_IRQ;
			MODE_SVC: loc.slot = SLOT_SVC;
			MODE_ABT: loc.slot = SLOT_ABT;
			MODE_UND: loc.slot = SLOT_UND;
			default: begin
				loc.hit  = 1'b0;
				loc.slot = '0;
			end
		endcase
		return loc;
	endfunction

	function automatic logic [31:0] reg_reset_val(input logic [REG_ADDR_W-1:0] addr);
		logic [31:0] v;
		case (addr)
			ADDR_USR_SP: v = STACK_USR_RESET;
			ADDR_SVC_SP: v = STACK_SVC_RESET;
			ADDR_IRQ_SP: v = STACK_IRQ_RESET;
			default:     v = '0;
		endcase
		return v;
	endfunction

	function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] nzcv);
		logic n;
		logic z;
		logic c;
		logic v;
		logic res;
		n = nzcv[3];
		z = nzcv[2];
		c = nzcv[1];
		v = nzcv[0];
		case (cond)
			COND_EQ: res = z;
			COND_NE: res = !z;
			COND_CS: res = c;
			COND_CC: res = !c;
			COND_MI: res = n;
			COND_PL: res = !n;
			COND_VS: res = v;
			COND_VC: res = !v;
			COND_HI: res = c && !z;
			COND_LS: res = !c || z;
			COND_GE: res = (n == v);
			COND_LT: res = (n != v);
			COND_GT: res = !z && (n == v);
			COND_LE: res = z || (n != v);
			COND_AL: res = 1'b1;
			default: res = 1'b0;
		endcase
		return res;
	endfunction

endpackage

@@ rtl/core/brf_regmem.sv @@
// banked register memory with per-entry valid bits and reset-value fill on read
module brf_regmem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [brf_pkg::REG_ADDR_W-1:0] rd_addr,
	output logic [31:0]                    rd_data,
	input  logic                           wr_en,
	input  logic [brf_pkg::REG_ADDR_W-1:0] wr_addr,
	input  logic [31:0]                    wr_data
);

	logic [31:0]                    mem [brf_pkg::REG_DEPTH];
	logic [brf_pkg::REG_DEPTH-1:0]  vld_q;
	logic [31:0]                    raw_q;
	logic                           raw_vld_q;
	logic [brf_pkg::REG_ADDR_W-1:0] addr_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_q  <= mem[rd_addr];
			addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			raw_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				raw_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// entries never written read as their reset value
	assign rd_data = raw_vld_q ? raw_q : brf_pkg::reg_reset_val(addr_q);

endmodule

@@ rtl/core/banked_register_file.sv @@
// top level of the banked register file with status words
// One command per input beat; every command returns exactly one result beat. In the accept
// cycle the register memory and the saved-status memory are read (synchronous, registered);
// in the execute state that follows, the result is formed and any write goes back to the
// memories, the pc or the status word. A new command is taken only once the last one has
// made its read-then-write pass through the memories. A new command is taken while a result
// still waits on the output register; the block only holds its execute state while the
// output register is full and not being taken. Banked registers r0-r14 of all modes live in
// one 30-entry memory, the five saved status words in a second one; the pc and the current
// status word are flip-flops. Memories start from their reset values at once through
// per-entry valid bits, so there is no clearing pass after reset.
module banked_register_file (
	input  logic        clk,
	input  logic        arst_n,
	// command beat
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] command, [7:4] reg_index, [12:8] mode_select, [44:13] write_data,
	// [48:45] cond_code, [55:49] zero
	input  logic [55:0] s_tdata,
	// [0] thumb_view
	input  logic        s_tuser,
	// result beat
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] read_data, [32] cond_pass, [33] pc_written, [34] mode_has_saved, [39:35] zero
	output logic [39:0] m_tdata
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic accept;
	logic fin;

	// input fields
	logic [3:0]  in_cmd;
	logic [3:0]  in_reg;
	logic [4:0]  in_mode;
	logic [31:0] in_data;
	logic [3:0]  in_cond;

	assign in_cmd  = s_tdata[3:0];
	assign in_reg  = s_tdata[7:4];
	assign in_mode = s_tdata[12:8];
	assign in_data = s_tdata[44:13];
	assign in_cond = s_tdata[48:45];

	// architectural state outside the memories
	logic [31:0] pc_q;
	logic [31:0] status_q;

	// command held for the execute cycle
	logic [3:0]        cmd_s1;
	logic [3:0]        reg_s1;
	logic [31:0]       data_s1;
	logic              thumb_s1;
	logic [3:0]        cond_s1;
	brf_pkg::reg_loc_t loc_s1;
	brf_pkg::sav_loc_t sav_s1;

	brf_pkg::reg_loc_t in_loc;
	brf_pkg::sav_loc_t in_sav;
	logic              named;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	// execute state finishes once the output register can take the result
	assign fin = (state_q == ST_EXEC) && (!m_tvalid || m_tready);

	// named-mode commands use mode_select, the others the current mode
	assign named  = (in_cmd == brf_pkg::CMD_READ_MODE) || (in_cmd == brf_pkg::CMD_WRITE_MODE);
	assign in_loc = brf_pkg::reg_loc(in_reg, named ? in_mode : status_q[4:0], !named);
	assign in_sav = brf_pkg::sav_loc(status_q[4:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: if (fin) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= in_cmd;
			reg_s1   <= in_reg;
			data_s1  <= in_data;
			thumb_s1 <= s_tuser;
			cond_s1  <= in_cond;
			loc_s1   <= in_loc;
			sav_s1   <= in_sav;
		end
	end

	// register memory
	logic [31:0]                    reg_rd_data;
	logic                           reg_wr_en;
	logic [brf_pkg::REG_ADDR_W-1:0] reg_wr_addr;
	logic [31:0]                    reg_wr_data;

	brf_regmem u_regmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_loc.addr),
		.rd_data (reg_rd_data),
		.wr_en   (reg_wr_en),
		.wr_addr (reg_wr_addr),
		.wr_data (reg_wr_data)
	);

	// saved status memory, reset value zero through valid bits
	logic [31:0]                   sav_mem [brf_pkg::SAV_DEPTH];
	logic [brf_pkg::SAV_DEPTH-1:0] sav_vld_q;
	logic [31:0]                   sav_raw_q;
	logic                          sav_raw_vld_q;
	logic                          sav_wr_en;
	logic [brf_pkg::SAV_ADDR_W-1:0] sav_wr_slot;
	logic [31:0]                   sav_wr_data;
	logic [31:0]                   sav_rd_data;

	always_ff @(posedge clk) begin
		if (sav_wr_en) begin
			sav_mem[sav_wr_slot] <= sav_wr_data;
		end
		if (accept) begin
			sav_raw_q <= sav_mem[in_sav.slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sav_vld_q     <= '0;
			sav_raw_vld_q <= 1'b0;
		end else begin
			if (sav_wr_en) begin
				sav_vld_q[sav_wr_slot] <= 1'b1;
			end
			if (accept) begin
				sav_raw_vld_q <= sav_vld_q[in_sav.slot];
			end
		end
	end

	assign sav_rd_data = sav_raw_vld_q ? sav_raw_q : '0;

	// execute: result and write-back
	logic              is_pc;
	logic              is_swi;
	logic [31:0]       pc_view;
	logic [31:0]       res_data;
	logic              res_pass;
	logic              res_pcw;
	logic [31:0]       status_nxt;
	logic [31:0]       pc_nxt;
	logic              res_has_saved;
	logic              reg_wr_cmd;
	brf_pkg::sav_loc_t nxt_sav;

	assign is_pc      = (reg_s1 == brf_pkg::REG_PC);
	assign is_swi     = (cmd_s1 == brf_pkg::CMD_SWI);
	assign pc_view    = pc_q + (thumb_s1 ? 32'd4 : 32'd8);
	assign reg_wr_cmd = (cmd_s1 == brf_pkg::CMD_WRITE) || (cmd_s1 == brf_pkg::CMD_WRITE_MODE);

	always_comb begin
		res_data   = '0;
		res_pass   = 1'b0;
		res_pcw    = 1'b0;
		status_nxt = status_q;
		pc_nxt     = pc_q;
		case (cmd_s1)
			brf_pkg::CMD_READ, brf_pkg::CMD_READ_MODE: begin
				if (is_pc) res_data = pc_view;
				else if (loc_s1.hit) res_data = reg_rd_data;
			end
			brf_pkg::CMD_WRITE, brf_pkg::CMD_WRITE_MODE: begin
				if (is_pc) begin
					pc_nxt  = data_s1 & brf_pkg::PC_ALIGN_MASK;
					res_pcw = 1'b1;
				end
			end
			brf_pkg::CMD_SPSR_READ: res_data = sav_s1.hit ? sav_rd_data : status_q;
			brf_pkg::CMD_CPSR_READ: res_data = status_q;
			brf_pkg::CMD_CPSR_WRITE: status_nxt = data_s1;
			brf_pkg::CMD_COND: res_pass = brf_pkg::cond_holds(cond_s1, status_q[31:28]);
			brf_pkg::CMD_SWI: begin
				// enter supervisor with irq masked, thumb and mode bits cleared
				status_nxt = (status_q & ~brf_pkg::SWI_CLEAR_MASK) | brf_pkg::IRQ_MASK_BIT
					| {27'd0, brf_pkg::MODE_SVC};
				pc_nxt     = brf_pkg::SWI_VECTOR;
				res_pcw    = 1'b1;
			end
			default: begin
				res_data = '0;
			end
		endcase
	end

	assign nxt_sav       = brf_pkg::sav_loc(status_nxt[4:0]);
	assign res_has_saved = nxt_sav.hit;

	// swi stores the return link into the svc bank, writes through a mode go to their cell
	assign reg_wr_en   = fin && ((reg_wr_cmd && !is_pc && loc_s1.hit) || is_swi);
	assign reg_wr_addr = is_swi ? brf_pkg::ADDR_SVC_LR : loc_s1.addr;
	assign reg_wr_data = is_swi ? pc_q + 32'd4 : data_s1;

	assign sav_wr_en   = fin && (((cmd_s1 == brf_pkg::CMD_SPSR_WRITE) && sav_s1.hit) || is_swi);
	assign sav_wr_slot = is_swi ? brf_pkg::SLOT_SVC : sav_s1.slot;
	assign sav_wr_data = is_swi ? status_q : data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= brf_pkg::PC_RESET;
			status_q <= brf_pkg::STATUS_RESET;
		end else if (fin) begin
			pc_q     <= pc_nxt;
			status_q <= status_nxt;
		end
	end

	// output register
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			m_tdata_q <= {5'd0, res_has_saved, res_pcw, res_pass, res_data};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// an accepted beat always moves into the execute cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted beat did not enter execute");

	// execute holds while the output register is blocked
	a_exec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EXEC) && m_tvalid && !m_tready) |=> (state_q == ST_EXEC) && m_tvalid)
		else $error("execute left while result blocked");

	// pc stays halfword aligned after any pc write
	a_pc_align: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && res_pcw) |=> !pc_q[0])
		else $error("pc bit 0 set after write");

	// software interrupt lands in supervisor mode at the vector
	a_swi_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && is_swi) |=> (status_q[4:0] == brf_pkg::MODE_SVC) && (pc_q == brf_pkg::SWI_VECTOR)
			&& m_tdata[34])
		else $error("swi entry state wrong");

endmodule
